// File: sv/mrfq_pkg.sv
// ----------------------------------------------------------------------------
// mrfq_pkg
// Shared types and constants for the response frame queue: field widths,
// operation codes, the sequencer state type and the stored entry layout.
// ----------------------------------------------------------------------------
package mrfq_pkg;

    localparam int ID_W      = 11;
    localparam int EXP_W     = 12;
    localparam int PAYLOAD_W = 64;
    localparam int NODE_W    = 7;
    localparam int FILL_W    = 6;

    localparam logic [ID_W-1:0] BASE_RESET = 11'd1408;

    // operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_TAKE = 1'b1;

    // sequencer states, one-hot
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SCAN  = 3'b010,
        S_SHIFT = 3'b100
    } t_state;

    // one stored frame
    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [PAYLOAD_W-1:0] payload;
    } t_entry;

endpackage

// File: sv/mrfq_ram.sv
// ----------------------------------------------------------------------------
// mrfq_ram
// Frame store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mrfq_ram
    import mrfq_pkg::*;
#(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  t_entry            i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output t_entry            o_rdata
);

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/match_remove_frame_queue_top.sv
// ----------------------------------------------------------------------------
// match_remove_frame_queue_top
// Push: result word in the cycle after start, busy stays low, one push a cycle
// while busy is low. Take: busy while the queue is scanned and, on a hit,
// compacted; entries are scanned and frames moved up one at a time through the
// single read port of the frame store; result word in the same cycle as busy
// falls. Receiver cannot stall; synchronous active-low reset empties the queue.
// ----------------------------------------------------------------------------
module match_remove_frame_queue_top
    import mrfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [ID_W-1:0]      i_cfg_wdata,
    // command
    input  logic                 start,
    output logic                 busy,
    input  logic                 i_op,
    input  logic [ID_W-1:0]      i_frame_id,
    input  logic [PAYLOAD_W-1:0] i_frame_payload,
    input  logic [NODE_W-1:0]    i_node,
    // result
    output logic                 o_valid,
    output logic                 o_found,
    output logic [PAYLOAD_W-1:0] o_match_payload,
    output logic                 o_dropped_oldest,
    output logic [FILL_W-1:0]    o_fill_count
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    // ring pointer helpers
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_LAST : p - PTR_W'(1);
    endfunction

    t_state                 r_state, n_state;
    logic [ID_W-1:0]        r_base, n_base;
    logic [PTR_W-1:0]       r_rd_pos, n_rd_pos;
    logic [PTR_W-1:0]       r_wr_pos, n_wr_pos;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [EXP_W-1:0]       r_expect, n_expect;
    logic [PTR_W-1:0]       r_iptr, n_iptr;
    logic [CNT_W-1:0]       r_icnt, n_icnt;
    logic [PTR_W-1:0]       r_cptr, n_cptr;
    logic [CNT_W-1:0]       r_cidx, n_cidx;
    logic                   r_pend, n_pend;
    logic                   r_valid, n_valid;
    logic                   r_found, n_found;
    logic [PAYLOAD_W-1:0]   r_mpay, n_mpay;
    logic                   r_drop, n_drop;

    // frame store request
    logic                   c_we;
    logic [PTR_W-1:0]       c_waddr;
    t_entry                 c_wdata;
    logic                   c_re;
    logic [PTR_W-1:0]       c_raddr;
    t_entry                 c_rdata;
    logic                   c_hit;

    mrfq_ram #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_re    (c_re),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    assign c_hit = r_pend && ({1'b0, c_rdata.id} == r_expect);

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_base   = r_base;
        n_rd_pos = r_rd_pos;
        n_wr_pos = r_wr_pos;
        n_count  = r_count;
        n_expect = r_expect;
        n_iptr   = r_iptr;
        n_icnt   = r_icnt;
        n_cptr   = r_cptr;
        n_cidx   = r_cidx;
        n_pend   = r_pend;
        n_valid  = 1'b0;
        n_found  = r_found;
        n_mpay   = r_mpay;
        n_drop   = r_drop;
        c_we     = 1'b0;
        c_waddr  = r_wr_pos;
        c_wdata  = '{id: i_frame_id, payload: i_frame_payload};
        c_re     = 1'b0;
        c_raddr  = r_iptr;

        if (i_cfg_we) begin
            n_base = i_cfg_wdata;
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_op == OP_PUSH) begin
                        // append, dropping the oldest frame when full
                        c_we     = 1'b1;
                        n_wr_pos = ptr_inc(r_wr_pos);
                        n_found  = 1'b0;
                        n_mpay   = '0;
                        n_valid  = 1'b1;
                        if (r_count == CNT_FULL) begin
                            n_rd_pos = ptr_inc(r_rd_pos);
                            n_drop   = 1'b1;
                        end else begin
                            n_count = r_count + CNT_W'(1);
                            n_drop  = 1'b0;
                        end
                    end else begin
                        n_expect = {1'b0, r_base} + EXP_W'(i_node);
                        n_iptr   = r_rd_pos;
                        n_icnt   = '0;
                        n_cptr   = r_rd_pos;
                        n_cidx   = '0;
                        n_pend   = 1'b0;
                        n_state  = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // issue the next read each cycle
                if (r_icnt < r_count) begin
                    c_re   = 1'b1;
                    n_iptr = ptr_inc(r_iptr);
                    n_icnt = r_icnt + CNT_W'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end

                if (r_count == '0) begin
                    // empty queue: nothing to find
                    n_found = 1'b0;
                    n_mpay  = '0;
                    n_drop  = 1'b0;
                    n_valid = 1'b1;
                    n_pend  = 1'b0;
                    n_state = S_IDLE;
                end else if (c_hit) begin
                    // first match: take it and start closing the gap
                    n_found = 1'b1;
                    n_mpay  = c_rdata.payload;
                    n_drop  = 1'b0;
                    n_iptr  = ptr_inc(r_cptr);
                    n_icnt  = r_cidx + CNT_W'(1);
                    n_pend  = 1'b0;
                    n_state = S_SHIFT;
                end else if (r_pend) begin
                    n_cptr = ptr_inc(r_cptr);
                    n_cidx = r_cidx + CNT_W'(1);
                    if (r_cidx == r_count - CNT_W'(1)) begin
                        n_found = 1'b0;
                        n_mpay  = '0;
                        n_drop  = 1'b0;
                        n_valid = 1'b1;
                        n_pend  = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end

            S_SHIFT: begin
                // write back the entry read last cycle one place earlier
                if (r_pend) begin
                    c_we    = 1'b1;
                    c_waddr = r_cptr;
                    c_wdata = c_rdata;
                    n_cptr  = ptr_inc(r_cptr);
                end
                if (r_icnt < r_count) begin
                    c_re   = 1'b1;
                    n_iptr = ptr_inc(r_iptr);
                    n_icnt = r_icnt + CNT_W'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (!r_pend && !(r_icnt < r_count)) begin
                    n_wr_pos = ptr_dec(r_wr_pos);
                    n_count  = r_count - CNT_W'(1);
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_base   <= BASE_RESET;
            r_rd_pos <= '0;
            r_wr_pos <= '0;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_base   <= n_base;
            r_rd_pos <= n_rd_pos;
            r_wr_pos <= n_wr_pos;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_valid  <= n_valid;
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        r_expect <= n_expect;
        r_iptr   <= n_iptr;
        r_icnt   <= n_icnt;
        r_cptr   <= n_cptr;
        r_cidx   <= n_cidx;
        r_found  <= n_found;
        r_mpay   <= n_mpay;
        r_drop   <= n_drop;
    end

    assign busy             = (r_state != S_IDLE);
    assign o_valid          = r_valid;
    assign o_found          = r_found;
    assign o_match_payload  = r_mpay;
    assign o_dropped_oldest = r_drop;
    assign o_fill_count     = FILL_W'(r_count);

`ifndef SYNTH
    // a result word always comes back with the sequencer idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobed while sequencer busy");

    // the queue never holds more than its depth
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("fill count above queue depth");

    // compaction only runs on a non-empty queue
    a_shift_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_count != '0))
        else $error("compaction on empty queue");

    // a drop leaves the queue full
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dropped_oldest) |-> (r_count == CNT_FULL))
        else $error("drop reported with queue not full");
`endif

endmodule

// File: verif/match_remove_frame_queue_top_tb.sv
// ----------------------------------------------------------------------------
// match_remove_frame_queue_top_tb
// Drives push and take commands into the response frame queue and checks every
// result word against a fixed expected word or a behavioral queue model in the
// bench. A directed table covers the empty queue, duplicate ids, the full-queue
// drop, base id extremes and expected ids past 11 bits. Random phases follow,
// each with its own base id, mostly frames aimed at a few nodes, random gaps.
// ----------------------------------------------------------------------------
module match_remove_frame_queue_top_tb;
    import mrfq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH  = 32;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 120;

    // one result word as the block reports it
    typedef struct packed {
        logic                 found;
        logic [PAYLOAD_W-1:0] payload;
        logic                 dropped;
        logic [FILL_W-1:0]    fill;
    } t_result;

    typedef enum logic {
        ROW_CMD,
        ROW_CFG
    } t_row_kind;

    // one line of the directed plan; a cfg row carries the base id in id
    typedef struct {
        t_row_kind            kind;
        logic                 op;
        logic [ID_W-1:0]      id;
        logic [PAYLOAD_W-1:0] payload;
        logic [NODE_W-1:0]    node;
        int                   reps;
        bit                   known;
        t_result              want;
    } t_plan_row;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_we        = 1'b0;
    logic [ID_W-1:0]      i_cfg_wdata     = '0;
    logic                 start           = 1'b0;
    logic                 busy;
    logic                 i_op            = OP_PUSH;
    logic [ID_W-1:0]      i_frame_id      = '0;
    logic [PAYLOAD_W-1:0] i_frame_payload = '0;
    logic [NODE_W-1:0]    i_node          = '0;
    logic                 o_valid;
    logic                 o_found;
    logic [PAYLOAD_W-1:0] o_match_payload;
    logic                 o_dropped_oldest;
    logic [FILL_W-1:0]    o_fill_count;

    // bench copy of the queue contents, oldest first, and of the base id
    t_entry          model_frames[$];
    logic [ID_W-1:0] model_base_id = BASE_RESET;

    t_result   pending_results[$];
    t_plan_row frame_plan[$];
    int        mismatch_count = 0;

    match_remove_frame_queue_top #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_frame_id      (i_frame_id),
        .i_frame_payload (i_frame_payload),
        .i_node          (i_node),
        .o_valid         (o_valid),
        .o_found         (o_found),
        .o_match_payload (o_match_payload),
        .o_dropped_oldest(o_dropped_oldest),
        .o_fill_count    (o_fill_count)
    );

    always #1 i_clk = ~i_clk;

    // hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("%0t ns: %s got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // apply one command to the bench queue and return its result word
    function automatic t_result predict_frame_op(input logic op, input logic [ID_W-1:0] id,
                                                 input logic [PAYLOAD_W-1:0] pay,
                                                 input logic [NODE_W-1:0] node);
        t_result          res;
        t_entry           ent;
        logic [EXP_W-1:0] want_id;
        int               hit;
        res = '0;
        if (op == OP_PUSH) begin
            // full queue loses its oldest frame first
            if (model_frames.size() >= QUEUE_DEPTH) begin
                void'(model_frames.pop_front());
                res.dropped = 1'b1;
            end
            ent.id      = id;
            ent.payload = pay;
            model_frames.push_back(ent);
        end else begin
            // expected id is formed at 12 bits, so a carry never matches
            want_id = {1'b0, model_base_id} + {{(EXP_W-NODE_W){1'b0}}, node};
            hit = -1;
            for (int i = 0; i < model_frames.size(); i++) begin
                if (hit < 0 && {1'b0, model_frames[i].id} == want_id)
                    hit = i;
            end
            if (hit >= 0) begin
                res.found   = 1'b1;
                res.payload = model_frames[hit].payload;
                model_frames.delete(hit);
            end
        end
        res.fill = FILL_W'(model_frames.size());
        return res;
    endfunction

    // present one command word and hold it until the block takes it
    task automatic issue_frame_op(input logic op, input logic [ID_W-1:0] id,
                                  input logic [PAYLOAD_W-1:0] pay,
                                  input logic [NODE_W-1:0] node,
                                  input bit known, input t_result fixed);
        t_result predicted;
        start           <= 1'b1;
        i_op            <= op;
        i_frame_id      <= id;
        i_frame_payload <= pay;
        i_node          <= node;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = predict_frame_op(op, id, pay, node);
        pending_results.push_back(known ? fixed : predicted);
    endtask

    task automatic hold_start(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // wait until every result word is in and the block is idle
    task automatic settle_queue();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0 || busy !== 1'b0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_base_id(input logic [ID_W-1:0] value);
        settle_queue();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        model_base_id = value;
    endtask

    function automatic void add_row(input t_row_kind kind, input logic op,
                                    input logic [ID_W-1:0] id,
                                    input logic [PAYLOAD_W-1:0] pay,
                                    input logic [NODE_W-1:0] node, input int reps,
                                    input bit known, input logic found,
                                    input logic [PAYLOAD_W-1:0] mpay,
                                    input logic dropped, input logic [FILL_W-1:0] fill);
        t_plan_row row;
        row.kind         = kind;
        row.op           = op;
        row.id           = id;
        row.payload      = pay;
        row.node         = node;
        row.reps         = reps;
        row.known        = known;
        row.want.found   = found;
        row.want.payload = mpay;
        row.want.dropped = dropped;
        row.want.fill    = fill;
        frame_plan.push_back(row);
    endfunction

    // result word check against the oldest pending expectation
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("result word with nothing pending", 64'(o_fill_count), 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_found !== want.found)
                    flag_mismatch("found", 64'(o_found), 64'(want.found));
                if (o_match_payload !== want.payload)
                    flag_mismatch("match_payload", o_match_payload, want.payload);
                if (o_dropped_oldest !== want.dropped)
                    flag_mismatch("dropped_oldest", 64'(o_dropped_oldest),
                                  64'(want.dropped));
                if (o_fill_count !== want.fill)
                    flag_mismatch("fill_count", 64'(o_fill_count), 64'(want.fill));
            end
        end
    end

    initial begin
        int                   push_pct;
        bit                   gaps_on;
        int                   gap_pick;
        logic                 op;
        logic [NODE_W-1:0]    node;
        logic [NODE_W-1:0]    push_node;
        logic [ID_W-1:0]      id;
        logic [PAYLOAD_W-1:0] pay;
        logic [ID_W-1:0]      base;

        // directed plan: kind, op, id, payload, node, reps, known, expected word
        add_row(ROW_CMD, OP_TAKE, 11'd0,    64'd0, 7'd0,   1, 1'b1, 1'b0, 64'd0, 1'b0, 6'd0);
        add_row(ROW_CMD, OP_PUSH, 11'd1408, '1,    7'd0,   1, 1'b1, 1'b0, 64'd0, 1'b0, 6'd1);
        add_row(ROW_CMD, OP_PUSH, 11'd2047, 64'd0, 7'd0,   1, 1'b1, 1'b0, 64'd0, 1'b0, 6'd2);
        add_row(ROW_CMD, OP_PUSH, 11'd0, 64'h0123_4567_89AB_CDEF, 7'd0,
                1, 1'b1, 1'b0, 64'd0, 1'b0, 6'd3);
        add_row(ROW_CMD, OP_PUSH, 11'd1535, 64'h8000_0000_0000_0001, 7'd127,
                1, 1'b1, 1'b0, 64'd0, 1'b0, 6'd4);
        add_row(ROW_CMD, OP_PUSH, 11'd1408, 64'hDEAD_BEEF_CAFE_F00D, 7'd0,
                1, 1'b1, 1'b0, 64'd0, 1'b0, 6'd5);
        // duplicate ids: the older one goes first
        add_row(ROW_CMD, OP_TAKE, 11'd0, 64'd0, 7'd0,   1, 1'b1, 1'b1, '1, 1'b0, 6'd4);
        add_row(ROW_CMD, OP_TAKE, 11'd0, 64'd0, 7'd0,   1, 1'b1, 1'b1,
                64'hDEAD_BEEF_CAFE_F00D, 1'b0, 6'd3);
        add_row(ROW_CMD, OP_TAKE, 11'd0, 64'd0, 7'd127, 1, 1'b1, 1'b1,
                64'h8000_0000_0000_0001, 1'b0, 6'd2);
        add_row(ROW_CMD, OP_TAKE, 11'd0, 64'd0, 7'd5,   1, 1'b1, 1'b0, 64'd0, 1'b0, 6'd2);
        // top base id: any node but 0 carries past 11 bits and must miss id 0
        add_row(ROW_CFG, OP_PUSH, 11'd2047, 64'd0, 7'd0, 1, 1'b0, 1'b0, 64'd0, 1'b0, 6'd0);
        add_row(ROW_CMD, OP_TAKE, 11'd0, 64'd0, 7'd1,   1, 1'b1, 1'b0, 64'd0, 1'b0, 6'd2);
        add_row(ROW_CMD, OP_TAKE, 11'd0, 64'd0, 7'd127, 1, 1'b1, 1'b0, 64'd0, 1'b0, 6'd2);
        add_row(ROW_CMD, OP_TAKE, 11'd0, 64'd0, 7'd0,   1, 1'b1, 1'b1, 64'd0, 1'b0, 6'd1);
        add_row(ROW_CFG, OP_PUSH, 11'd0,    64'd0, 7'd0, 1, 1'b0, 1'b0, 64'd0, 1'b0, 6'd0);
        add_row(ROW_CMD, OP_TAKE, 11'd0, 64'd0, 7'd0,   1, 1'b1, 1'b1,
                64'h0123_4567_89AB_CDEF, 1'b0, 6'd0);
        // fill to capacity, then overflow twice and pull from the middle
        add_row(ROW_CMD, OP_PUSH, 11'd5, 64'h1000, 7'd0, QUEUE_DEPTH, 1'b0, 1'b0, 64'd0,
                1'b0, 6'd0);
        add_row(ROW_CMD, OP_PUSH, 11'd6, 64'h2000, 7'd0, 2, 1'b0, 1'b0, 64'd0, 1'b0, 6'd0);
        add_row(ROW_CMD, OP_TAKE, 11'd0, 64'd0, 7'd6, 1, 1'b0, 1'b0, 64'd0, 1'b0, 6'd0);
        add_row(ROW_CMD, OP_TAKE, 11'd0, 64'd0, 7'd5, 1, 1'b0, 1'b0, 64'd0, 1'b0, 6'd0);
        add_row(ROW_CMD, OP_PUSH, 11'd7, 64'h3000, 7'd0, 1, 1'b0, 1'b0, 64'd0, 1'b0, 6'd0);

        // reset
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        model_frames.delete();
        model_base_id = BASE_RESET;
        repeat (2) @(posedge i_clk);

        // walk the directed plan
        foreach (frame_plan[k]) begin
            if (frame_plan[k].kind == ROW_CFG) begin
                write_base_id(frame_plan[k].id);
            end else begin
                for (int j = 0; j < frame_plan[k].reps; j++)
                    issue_frame_op(frame_plan[k].op, frame_plan[k].id,
                                   frame_plan[k].payload + j, frame_plan[k].node,
                                   frame_plan[k].known, frame_plan[k].want);
            end
        end

        // random phases, each with its own base id
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                1: base = '0;
                2: base = '1;
                3: base = ID_W'($urandom_range(1921, 2047));
                default: base = ID_W'($urandom_range(0, 2047));
            endcase
            write_base_id(base);
            push_pct = 50;
            gaps_on  = 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // new push/take mix and idling mode every 20 words
                if (n % 20 == 0) begin
                    push_pct = $urandom_range(15, 90);
                    gaps_on  = ($urandom_range(0, 2) != 0);
                end
                op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_TAKE;
                // mostly a handful of nodes so that takes find their frames
                node      = ($urandom_range(0, 3) == 0) ? NODE_W'($urandom_range(0, 127))
                                                        : NODE_W'($urandom_range(0, 7));
                push_node = ($urandom_range(0, 3) == 0) ? NODE_W'($urandom_range(0, 127))
                                                        : NODE_W'($urandom_range(0, 7));
                id  = ($urandom_range(0, 3) == 0) ? ID_W'($urandom_range(0, 2047))
                                                  : ID_W'(model_base_id + push_node);
                pay = {$urandom, $urandom};
                issue_frame_op(op, id, pay, node, 1'b0, '0);
                if (gaps_on) begin
                    gap_pick = $urandom_range(0, 9);
                    if (gap_pick == 9)
                        hold_start($urandom_range(10, 40));
                    else if (gap_pick >= 6)
                        hold_start($urandom_range(1, 3));
                end
            end
        end

        // drain and finish
        settle_queue();
        repeat (QUEUE_DEPTH + 8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
